>>> sv/mpa_pkg.sv
`timescale 1ns / 1ps

package mpa_pkg;

    // Operation selector codes carried on s_axis_tuser
    localparam logic [2:0] OP_RX_BYTE     = 3'd0;
    localparam logic [2:0] OP_ADD_DELTA   = 3'd1;
    localparam logic [2:0] OP_SET_BUTTONS = 3'd2;
    localparam logic [2:0] OP_READ_X      = 3'd3;
    localparam logic [2:0] OP_READ_Y      = 3'd4;

    // Framer phase codes: position of the next expected mouse byte
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic [7:0] FIRST_OK_BIT = 8'h08;
    localparam logic [7:0] OVF_BITS     = 8'hC0;
    localparam logic [7:0] BTN_BITS     = 8'h07;

    localparam int ACC_WIDTH_DEF = 16;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [15:0] read_value;
        logic [7:0]  button_state;
        logic        packet_complete;
        logic [1:0]  packet_phase;
    } mpa_result_t;

endpackage

>>> sv/mouse_packet_accumulator.sv
`timescale 1ns / 1ps
// Each accepted transaction's result is registered into the output entry, or the skid entry while the output stalls.
// Throughput: one transaction per cycle while s_axis_tready is high; the state update is a single add and clamp.
// A two-entry output buffer keeps s_axis_tready high through one stalled result.
// Reset (aresetn low, synchronous) clears framer phase, bytes, accumulators,
// buttons and the valid flags of both output buffer entries.

module mouse_packet_accumulator #(
    parameter int ACC_WIDTH = mpa_pkg::ACC_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] rx_byte, [23:8] add_x, [39:24] add_y, [47:40] new_button_bits
    input  logic [mpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] read_value, [23:16] button_state, [25:24] packet_phase, [31:26] zero
    output logic [mpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // packet_complete
    output logic                            m_axis_tlast
);

    logic                 accept;
    mpa_pkg::mpa_result_t core_result;
    mpa_pkg::mpa_result_t out_result;

    assign accept = s_axis_tvalid && s_axis_tready;

    mpa_core #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .operation       (s_axis_tuser),
        .rx_byte         (s_axis_tdata[7:0]),
        .add_x           (s_axis_tdata[23:8]),
        .add_y           (s_axis_tdata[39:24]),
        .new_button_bits (s_axis_tdata[47:40]),
        .result          (core_result)
    );

    mpa_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_result  (core_result),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {6'd0, out_result.packet_phase, out_result.button_state,
                           out_result.read_value};
    assign m_axis_tlast = out_result.packet_complete;

    // Input only stalls while a result is waiting at the output
    a_ready_low_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("s_axis_tready low with no pending result");

    // A completed packet always leaves the framer expecting a first byte
    a_complete_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[25:24] == mpa_pkg::PH_FIRST))
        else $error("packet complete with nonzero phase");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[25:24] != 2'd3))
        else $error("unreachable framer phase on output");

    // An accepted transaction always leaves m_axis_tvalid high next cycle
    a_accept_output: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_axis_tvalid)
        else $error("accepted transaction produced no result");

endmodule

>>> sv/mpa_core.sv
`timescale 1ns / 1ps

module mpa_core #(
    parameter int ACC_WIDTH = mpa_pkg::ACC_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [2:0]          operation,
    input  logic [7:0]          rx_byte,
    input  logic [15:0]         add_x,
    input  logic [15:0]         add_y,
    input  logic [7:0]          new_button_bits,
    output mpa_pkg::mpa_result_t result
);

    localparam int SUM_W = ((ACC_WIDTH > 16) ? ACC_WIDTH : 16) + 1;

    localparam logic signed [SUM_W-1:0] ACC_MAX =
        {{(SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN =
        {{(SUM_W - ACC_WIDTH + 1){1'b1}}, {(ACC_WIDTH - 1){1'b0}}};

    logic [1:0]           phase_reg,       phase_next;
    logic [7:0]           first_byte_reg,  first_byte_next;
    logic [7:0]           second_byte_reg, second_byte_next;
    logic [ACC_WIDTH-1:0] accum_x_reg,     accum_x_next;
    logic [ACC_WIDTH-1:0] accum_y_reg,     accum_y_next;
    logic [7:0]           button_reg,      button_next;

    logic signed [SUM_W-1:0] acc_x_ext, acc_y_ext;
    logic signed [SUM_W-1:0] dx_ext, dy_ext;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic [ACC_WIDTH-1:0]    sat_x, sat_y;

    assign acc_x_ext = {{(SUM_W - ACC_WIDTH){accum_x_reg[ACC_WIDTH-1]}}, accum_x_reg};
    assign acc_y_ext = {{(SUM_W - ACC_WIDTH){accum_y_reg[ACC_WIDTH-1]}}, accum_y_reg};

    // Motion: add_x/add_y for OP_ADD_DELTA, else X from the second byte, Y inverted from the third
    always_comb begin
        if (operation == mpa_pkg::OP_ADD_DELTA) begin
            dx_ext = {{(SUM_W - 16){add_x[15]}}, add_x};
            dy_ext = {{(SUM_W - 16){add_y[15]}}, add_y};
        end else begin
            dx_ext = {{(SUM_W - 8){second_byte_reg[7]}}, second_byte_reg};
            dy_ext = -{{(SUM_W - 8){rx_byte[7]}}, rx_byte};
        end
    end

    assign sum_x = acc_x_ext + dx_ext;
    assign sum_y = acc_y_ext + dy_ext;

    // Clamp to the accumulator range
    always_comb begin
        if (sum_x > ACC_MAX) begin
            sat_x = ACC_MAX[ACC_WIDTH-1:0];
        end else if (sum_x < ACC_MIN) begin
            sat_x = ACC_MIN[ACC_WIDTH-1:0];
        end else begin
            sat_x = sum_x[ACC_WIDTH-1:0];
        end
        if (sum_y > ACC_MAX) begin
            sat_y = ACC_MAX[ACC_WIDTH-1:0];
        end else if (sum_y < ACC_MIN) begin
            sat_y = ACC_MIN[ACC_WIDTH-1:0];
        end else begin
            sat_y = sum_y[ACC_WIDTH-1:0];
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        accum_x_next     = accum_x_reg;
        accum_y_next     = accum_y_reg;
        button_next      = button_reg;
        result.read_value      = 16'd0;
        result.packet_complete = 1'b0;
        case (operation)
            mpa_pkg::OP_RX_BYTE: begin
                case (phase_reg)
                    mpa_pkg::PH_SECOND: begin
                        second_byte_next = rx_byte;
                        phase_next       = mpa_pkg::PH_THIRD;
                    end
                    mpa_pkg::PH_THIRD: begin
                        phase_next             = mpa_pkg::PH_FIRST;
                        result.packet_complete = 1'b1;
                        // Drop motion when either overflow flag is set
                        if ((first_byte_reg & mpa_pkg::OVF_BITS) == 8'd0) begin
                            accum_x_next = sat_x;
                            accum_y_next = sat_y;
                        end
                        button_next = first_byte_reg & mpa_pkg::BTN_BITS;
                    end
                    default: begin
                        first_byte_next = rx_byte;
                        phase_next = ((rx_byte & mpa_pkg::FIRST_OK_BIT) != 8'd0) ?
                                     mpa_pkg::PH_SECOND : mpa_pkg::PH_FIRST;
                    end
                endcase
            end
            mpa_pkg::OP_ADD_DELTA: begin
                accum_x_next = sat_x;
                accum_y_next = sat_y;
            end
            mpa_pkg::OP_SET_BUTTONS: begin
                button_next = new_button_bits;
            end
            mpa_pkg::OP_READ_X: begin
                result.read_value = acc_x_ext[15:0];
                accum_x_next      = '0;
            end
            mpa_pkg::OP_READ_Y: begin
                result.read_value = acc_y_ext[15:0];
                accum_y_next      = '0;
            end
            default: begin
            end
        endcase
        result.button_state = button_next;
        result.packet_phase = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= mpa_pkg::PH_FIRST;
            first_byte_reg  <= 8'd0;
            second_byte_reg <= 8'd0;
            accum_x_reg     <= '0;
            accum_y_reg     <= '0;
            button_reg      <= 8'd0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
            accum_x_reg     <= accum_x_next;
            accum_y_reg     <= accum_y_next;
            button_reg      <= button_next;
        end
    end

endmodule

>>> sv/mpa_out_buf.sv
`timescale 1ns / 1ps

module mpa_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mpa_pkg::mpa_result_t in_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mpa_pkg::mpa_result_t out_result
);

    logic                 out_valid_reg,  out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    mpa_pkg::mpa_result_t out_reg,        out_next;
    mpa_pkg::mpa_result_t skid_reg,       skid_next;

    assign in_ready   = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready) begin
            // Output slot frees: drain the skid entry first
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = in_result;
                out_valid_next = in_valid;
            end
        end else if (in_valid && in_ready) begin
            // Hold the new transaction behind the stalled one
            skid_next       = in_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

>>> dv/mouse_motion_checker.sv
`timescale 1ns / 1ps

module mouse_motion_checker #(
    parameter int ACC_WIDTH = mpa_pkg::ACC_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [mpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [2:0]                      s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [mpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            m_axis_tlast,
    output int                              mismatch_count,
    output int                              reports_pending
);

    localparam longint ACC_MAX = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    logic [1:0]           pred_phase;
    logic [7:0]           pred_first;
    logic [7:0]           pred_second;
    logic [7:0]           pred_buttons;
    longint               pred_acc_x;
    longint               pred_acc_y;
    mpa_pkg::mpa_result_t expected_reports[$];
    int                   failures = 0;

    function automatic longint clamp_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > ACC_MAX) return ACC_MAX;
        if (s < ACC_MIN) return ACC_MIN;
        return s;
    endfunction

    // Advance the framer and accumulators by one transaction; return the report it yields.
    function automatic mpa_pkg::mpa_result_t predict_report(
        logic [2:0] op,
        logic [mpa_pkg::IN_TDATA_W-1:0] data
    );
        mpa_pkg::mpa_result_t rep;
        logic [7:0]           rx;
        rx  = data[7:0];
        rep = '0;
        case (op)
            mpa_pkg::OP_RX_BYTE: begin
                if (pred_phase == mpa_pkg::PH_SECOND) begin
                    pred_second = rx;
                    pred_phase  = mpa_pkg::PH_THIRD;
                end else if (pred_phase == mpa_pkg::PH_THIRD) begin
                    pred_phase = mpa_pkg::PH_FIRST;
                    rep.packet_complete = 1'b1;
                    // overflow packets still update the buttons
                    if ((pred_first & mpa_pkg::OVF_BITS) == 8'h00) begin
                        pred_acc_x = clamp_add(pred_acc_x, longint'($signed(pred_second)));
                        pred_acc_y = clamp_add(pred_acc_y, -longint'($signed(rx)));
                    end
                    pred_buttons = pred_first & mpa_pkg::BTN_BITS;
                end else begin
                    // phase 3 falls in here as well
                    pred_first = rx;
                    pred_phase = ((rx & mpa_pkg::FIRST_OK_BIT) != 8'h00) ?
                                 mpa_pkg::PH_SECOND : mpa_pkg::PH_FIRST;
                end
            end
            mpa_pkg::OP_ADD_DELTA: begin
                pred_acc_x = clamp_add(pred_acc_x, longint'($signed(data[23:8])));
                pred_acc_y = clamp_add(pred_acc_y, longint'($signed(data[39:24])));
            end
            mpa_pkg::OP_SET_BUTTONS: pred_buttons = data[47:40];
            mpa_pkg::OP_READ_X: begin
                rep.read_value = pred_acc_x[15:0];
                pred_acc_x = 0;
            end
            mpa_pkg::OP_READ_Y: begin
                rep.read_value = pred_acc_y[15:0];
                pred_acc_y = 0;
            end
            default: ;
        endcase
        rep.button_state = pred_buttons;
        rep.packet_phase = pred_phase;
        return rep;
    endfunction

    always @(posedge aclk) begin
        mpa_pkg::mpa_result_t want;
        mpa_pkg::mpa_result_t got;
        if (!aresetn) begin
            pred_phase   = mpa_pkg::PH_FIRST;
            pred_first   = '0;
            pred_second  = '0;
            pred_buttons = '0;
            pred_acc_x   = 0;
            pred_acc_y   = 0;
            expected_reports.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.read_value      = m_axis_tdata[15:0];
                got.button_state    = m_axis_tdata[23:16];
                got.packet_phase    = m_axis_tdata[25:24];
                got.packet_complete = m_axis_tlast;
                if (expected_reports.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: report with none pending: read=%0d buttons=%02h %s",
                                 $time, $signed(got.read_value), got.button_state,
                                 $sformatf("done=%0b phase=%0d",
                                           got.packet_complete, got.packet_phase));
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("%0t: report mismatch", $time);
                            $display("  expected read=%0d buttons=%02h done=%0b phase=%0d",
                                     $signed(want.read_value), want.button_state,
                                     want.packet_complete, want.packet_phase);
                            $display("  got      read=%0d buttons=%02h done=%0b phase=%0d",
                                     $signed(got.read_value), got.button_state,
                                     got.packet_complete, got.packet_phase);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_reports.push_back(predict_report(s_axis_tuser, s_axis_tdata));
        end
        mismatch_count  <= failures;
        reports_pending <= expected_reports.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int         ACC_W       = mpa_pkg::ACC_WIDTH_DEF;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int         TOTAL_ITEMS = 1450;
    localparam int         IDLE_LIMIT  = 2000;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [mpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [2:0]                      s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [mpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    int mismatch_count;
    int reports_pending;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    mouse_packet_accumulator #(.ACC_WIDTH(ACC_W)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    mouse_motion_checker #(.ACC_WIDTH(ACC_W)) motion_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    function automatic logic [mpa_pkg::IN_TDATA_W-1:0] noise();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[mpa_pkg::IN_TDATA_W-1:0];
    endfunction

    // Offer one transaction, wait for it to be taken, then pace the next burst.
    task automatic send_item(input logic [2:0] op,
                             input logic [mpa_pkg::IN_TDATA_W-1:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic [mpa_pkg::IN_TDATA_W-1:0] d;
        d = noise();
        d[7:0] = b;
        send_item(mpa_pkg::OP_RX_BYTE, d);
    endtask

    task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2);
        send_byte(b0);
        send_byte(b1);
        send_byte(b2);
    endtask

    task automatic send_delta(input logic [15:0] dx, input logic [15:0] dy);
        logic [mpa_pkg::IN_TDATA_W-1:0] d;
        d = noise();
        d[23:8]  = dx;
        d[39:24] = dy;
        send_item(mpa_pkg::OP_ADD_DELTA, d);
    endtask

    task automatic send_buttons(input logic [7:0] b);
        logic [mpa_pkg::IN_TDATA_W-1:0] d;
        d = noise();
        d[47:40] = b;
        send_item(mpa_pkg::OP_SET_BUTTONS, d);
    endtask

    // Hold the input idle until every outstanding report has been taken.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (reports_pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [7:0]  first;
        logic [15:0] dx;
        logic [15:0] dy;
        int          pick;
        bit          paused;
        paused = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(mpa_pkg::OP_READ_X, noise());
        send_byte(8'h00);                      // no sync bit: dropped
        send_byte(8'hF7);                      // every bit but sync: dropped
        send_packet(8'h0F, 8'h7F, 8'h80);      // largest X, most negative Y byte
        send_packet(8'hC8, 8'h55, 8'h55);      // overflow: buttons only
        send_delta(16'h7FFF, 16'h7FFF);
        send_packet(8'h0A, 8'h7F, 8'h80);      // push past the top bound
        send_item(mpa_pkg::OP_READ_X, noise());
        send_item(mpa_pkg::OP_READ_Y, noise());
        send_delta(16'h8000, 16'h8000);
        send_delta(16'h8000, 16'h8000);
        send_packet(8'h08, 8'h80, 8'h7F);      // push past the bottom bound
        send_item(mpa_pkg::OP_READ_X, noise());
        send_item(mpa_pkg::OP_READ_Y, noise());
        send_buttons(8'hFF);
        send_buttons(8'h00);
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            send_item(3'(op), noise());
        drain();

        while (items_sent < TOTAL_ITEMS) begin
            if (!paused && items_sent >= TOTAL_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                first = 8'($urandom_range(0, 255)) | mpa_pkg::FIRST_OK_BIT;
                if ($urandom_range(0, 3) != 0)
                    first = first & ~mpa_pkg::OVF_BITS;
                send_packet(first, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (pick < 62) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 72) begin
                if ($urandom_range(0, 9) < 7) begin
                    dx = 16'($urandom_range(0, 600) - 300);
                    dy = 16'($urandom_range(0, 600) - 300);
                end else begin
                    dx = 16'($urandom());
                    dy = 16'($urandom());
                end
                send_delta(dx, dy);
            end else if (pick < 78) begin
                send_buttons(8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                send_item(mpa_pkg::OP_READ_X, noise());
            end else if (pick < 96) begin
                send_item(mpa_pkg::OP_READ_Y, noise());
            end else begin
                send_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), noise());
            end
        end
        drain();
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Cycle the receiver through steady, random, patterned and long hold-off stretches.
    initial begin
        int seg;
        seg = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            for (int k = 0; k < 150; k++) begin
                case (seg % 5)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ((k % 5) >= 2);
                    3:       m_axis_tready <= (k >= 100);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge aclk);
            end
            seg++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> sim.f
sv/mpa_pkg.sv
sv/mpa_core.sv
sv/mpa_out_buf.sv
sv/mouse_packet_accumulator.sv
dv/mouse_motion_checker.sv
dv/testbench.sv
